@@ design/kst_pkg.sv @@
// Package with word types and fixed field widths of the spanning tree engine.
`timescale 1ns / 1ps
`default_nettype none
package kst_pkg;

  localparam int NODE_BITS  = 5;
  localparam int WIDTH_W    = 24;
  localparam int TOTAL_BITS = 29;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [NODE_BITS-1:0] from_node;
    logic [NODE_BITS-1:0] to_node;
    logic [WIDTH_W-1:0]   weight;
    logic                 last_edge;
  } edge_word_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]  tree_from;
    logic [NODE_BITS-1:0]  tree_to;
    logic [WIDTH_W-1:0]    tree_weight;
    logic [TOTAL_BITS-1:0] total_weight;
    logic                  is_edge;
    logic                  overflow;
    logic                  last_result;
  } result_word_t;

endpackage
`default_nettype wire

@@ design/kst_if.sv @@
// Valid/ready channel interfaces for edge words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface kst_edge_if;
  logic                valid;
  logic                ready;
  kst_pkg::edge_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kst_result_if;
  logic                  valid;
  logic                  ready;
  kst_pkg::result_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/kst_ram.sv @@
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/kruskal_spanning_tree_engine.sv @@
// Top level: edge store, stable insertion sort and Kruskal label walk.
`timescale 1ns / 1ps
`default_nettype none
// Edges load one per cycle into an edge RAM until a word marked last_edge
// arrives (words beyond MAX_EDGES are dropped and flag overflow). The block
// then sorts the RAM in place by a stable insertion sort; each key fetch and
// each shift step reads through the single RAM read port. A scan follows:
// each accepted edge adds a relabel walk over the label RAM. Results leave in
// ascending weight order through an output register; the final one carries
// last_result. After each graph, and after reset, a clearing pass rewrites
// every node label to its own index; the block takes no edge word while it
// sorts, scans or clears.
module kruskal_spanning_tree_engine #(
  parameter int MAX_NODES   = 32,
  parameter int MAX_EDGES   = 1024,
  parameter int WEIGHT_BITS = 24
) (
  input wire logic      clk,
  input wire logic      rst,
  kst_edge_if.sink      edges,
  kst_result_if.source  results
);
  import kst_pkg::*;

  localparam int WU = (WEIGHT_BITS < WIDTH_W) ? WEIGHT_BITS : WIDTH_W;
  localparam int EW = 2 * NODE_BITS + WU;
  localparam int AW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int LW = $clog2(MAX_NODES);
  localparam int NCW = (LW > NODE_BITS) ? LW + 1 : NODE_BITS + 1;

  typedef enum logic [13:0] {
    S_INIT   = 14'b00000000000001,
    S_LOAD   = 14'b00000000000010,
    S_OUTER  = 14'b00000000000100,
    S_KEY    = 14'b00000000001000,
    S_CMP_RD = 14'b00000000010000,
    S_CMP    = 14'b00000000100000,
    S_E_RD   = 14'b00000001000000,
    S_E      = 14'b00000010000000,
    S_LA     = 14'b00000100000000,
    S_LB     = 14'b00001000000000,
    S_PUSH   = 14'b00010000000000,
    S_RL_RD  = 14'b00100000000000,
    S_RL     = 14'b01000000000000,
    S_FINAL  = 14'b10000000000000
  } state_t;

  state_t state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [LW-1:0] k;
  logic [EW-1:0] key;
  logic [EW-1:0] e;
  logic [LW-1:0] la;
  logic [LW-1:0] lb;
  logic [TOTAL_BITS-1:0] total;
  logic ovf;
  logic pend_valid;
  result_word_t pend;
  logic out_valid;
  result_word_t out_word;
  result_word_t fin_word;

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [EW-1:0] st_wdata;
  logic [AW-1:0] st_raddr;
  logic [EW-1:0] st_rdata;
  logic          lb_we;
  logic [LW-1:0] lb_waddr;
  logic [LW-1:0] lb_wdata;
  logic [LW-1:0] lb_raddr;
  logic [LW-1:0] lb_rdata;

  logic [TOTAL_BITS:0] sum;
  logic [TOTAL_BITS-1:0] sat_total;
  logic nodes_ok;
  logic [NODE_BITS-1:0] e_from;
  logic [NODE_BITS-1:0] e_to;
  logic [WU-1:0] e_w;

  kst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  kst_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_label (
    .clk(clk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
    .raddr(lb_raddr), .rdata(lb_rdata)
  );

  assign edges.ready   = (state == S_LOAD);
  assign results.valid = out_valid;
  assign results.data  = out_word;

  assign e_from = e[EW-1 -: NODE_BITS];
  assign e_to   = e[EW-NODE_BITS-1 -: NODE_BITS];
  assign e_w    = e[WU-1:0];

  // saturating running total
  assign sum       = {1'b0, total} + (TOTAL_BITS + 1)'(e_w);
  assign sat_total = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

  // both ends of the fetched edge inside the node range
  assign nodes_ok =
    (NCW'(st_rdata[EW-1 -: NODE_BITS]) < NCW'(MAX_NODES)) &&
    (NCW'(st_rdata[EW-NODE_BITS-1 -: NODE_BITS]) < NCW'(MAX_NODES));

  // final word: pending edge or empty word, marked last
  always_comb begin
    fin_word             = pend_valid ? pend : '0;
    fin_word.overflow    = ovf;
    fin_word.last_result = 1'b1;
  end

  // RAM port steering
  always_comb begin
    st_we    = 1'b0;
    st_waddr = cnt[AW-1:0];
    st_wdata = {edges.data.from_node, edges.data.to_node, edges.data.weight[WU-1:0]};
    st_raddr = i[AW-1:0];
    lb_we    = 1'b0;
    lb_waddr = k;
    lb_wdata = k;
    lb_raddr = k;
    case (state)
      S_INIT: lb_we = 1'b1;
      S_LOAD: st_we = edges.valid && (cnt < CW'(MAX_EDGES));
      S_CMP_RD: begin
        st_raddr = AW'(j - CW'(1));
        st_waddr = j[AW-1:0];
        st_wdata = key;
        st_we    = (j == '0);
      end
      S_CMP: begin
        st_waddr = j[AW-1:0];
        st_we    = 1'b1;
        st_wdata = (st_rdata[WU-1:0] > key[WU-1:0]) ? st_rdata : key;
      end
      S_E: lb_raddr = LW'(st_rdata[EW-1 -: NODE_BITS]);
      S_LA: lb_raddr = LW'(e_to);
      S_RL: begin
        lb_we    = (lb_rdata == la);
        lb_wdata = lb;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      k          <= '0;
      cnt        <= '0;
      total      <= '0;
      ovf        <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // drop the output word once taken
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          k <= k + LW'(1);
          if (k == LW'(MAX_NODES - 1)) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (edges.valid) begin
            if (cnt < CW'(MAX_EDGES)) begin
              cnt <= cnt + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (edges.data.last_edge) begin
              i     <= CW'(1);
              state <= S_OUTER;
            end
          end
        end
        S_OUTER: begin
          if (i >= cnt) begin
            i     <= '0;
            state <= S_E_RD;
          end else begin
            state <= S_KEY;
          end
        end
        S_KEY: begin
          key   <= st_rdata;
          j     <= i;
          state <= S_CMP_RD;
        end
        S_CMP_RD: begin
          if (j == '0) begin
            i     <= i + CW'(1);
            state <= S_OUTER;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (st_rdata[WU-1:0] > key[WU-1:0]) begin
            j     <= j - CW'(1);
            state <= S_CMP_RD;
          end else begin
            i     <= i + CW'(1);
            state <= S_OUTER;
          end
        end
        S_E_RD: begin
          if (i >= cnt) begin
            state <= S_FINAL;
          end else begin
            state <= S_E;
          end
        end
        S_E: begin
          e <= st_rdata;
          if (nodes_ok) begin
            state <= S_LA;
          end else begin
            i     <= i + CW'(1);
            state <= S_E_RD;
          end
        end
        S_LA: begin
          la    <= lb_rdata;
          state <= S_LB;
        end
        S_LB: begin
          lb <= lb_rdata;
          if (lb_rdata == la) begin
            i     <= i + CW'(1);
            state <= S_E_RD;
          end else begin
            total <= sat_total;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          // hold until the previous pending word can move out
          if (!(pend_valid && out_valid)) begin
            if (pend_valid) begin
              out_word  <= pend;
              out_valid <= 1'b1;
            end
            pend.tree_from    <= e_from;
            pend.tree_to      <= e_to;
            pend.tree_weight  <= WIDTH_W'(e_w);
            pend.total_weight <= total;
            pend.is_edge      <= 1'b1;
            pend.overflow     <= ovf;
            pend.last_result  <= 1'b0;
            pend_valid        <= 1'b1;
            k                 <= '0;
            state             <= S_RL_RD;
          end
        end
        S_RL_RD: state <= S_RL;
        S_RL: begin
          k <= k + LW'(1);
          if (k == LW'(MAX_NODES - 1)) begin
            i     <= i + CW'(1);
            state <= S_E_RD;
          end else begin
            state <= S_RL_RD;
          end
        end
        S_FINAL: begin
          if (!out_valid) begin
            out_word   <= fin_word;
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
            cnt        <= '0;
            total      <= '0;
            ovf        <= 1'b0;
            k          <= '0;
            state      <= S_INIT;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

endmodule
`default_nettype wire
